/* sv/preemptive_priority_scheduler_top_macros.svh */
// assertion helpers shared by the checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define PPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication, ignored while reset is held
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

/* sv/ppsch_pkg.sv */
package ppsch_pkg;

  localparam int PROCS = 16;
  localparam int IDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int CNT_W = $clog2(PROCS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADBURST = 3'd2;
  localparam logic [2:0] ST_IDLE     = 3'd3;
  localparam logic [2:0] ST_RAN      = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RUN,
    S_CALC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic dec_en;
    logic restart;
  } cell_ctl_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [7:0]  prio;
    idx_t        idx;
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] left;
  } carry_t;

endpackage

/* sv/ppsch_cell.sv */
module ppsch_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppsch_pkg::idx_t      idx,
  input  ppsch_pkg::cell_ctl_t ctl,
  input  ppsch_pkg::entry_t    ld_data,
  input  logic [31:0]          clock_now,
  input  ppsch_pkg::carry_t    cin,
  output ppsch_pkg::carry_t    cout
);

  logic              valid_r;
  ppsch_pkg::entry_t ent_r;
  logic [15:0]       left_r;
  ppsch_pkg::carry_t cout_r;
  ppsch_pkg::carry_t cout_nxt;
  logic              eligible;
  logic              take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ent_r  <= ld_data;
      left_r <= ld_data.burst;
    end else if (ctl.restart && valid_r) begin
      left_r <= ent_r.burst;
    end else if (ctl.dec_en) begin
      left_r <= left_r - 16'd1;
    end
  end

  // strict less-than keeps the earlier-loaded entry on a tie
  always_comb begin
    eligible = valid_r && ({16'd0, ent_r.arrival} <= clock_now) && (left_r != 16'd0);
    take     = eligible && (!cin.found || (ent_r.prio < cin.prio));
    cout_nxt = cin;
    if (take) begin
      cout_nxt.found   = 1'b1;
      cout_nxt.prio    = ent_r.prio;
      cout_nxt.idx     = idx;
      cout_nxt.id      = ent_r.id;
      cout_nxt.arrival = ent_r.arrival;
      cout_nxt.burst   = ent_r.burst;
      cout_nxt.left    = left_r;
    end
  end

  always_ff @(posedge clk) begin
    cout_r <= cout_nxt;
  end

  assign cout = cout_r;

endmodule

/* sv/preemptive_priority_scheduler_top.sv */
// load, restart and reserved items: result valid 1 cycle after acceptance
// tick items: result valid PROCS + 2 cycles after acceptance (18), one more when the entry completes
// next item taken the cycle after the result is posted: 2 cycles per load, PROCS + 3 per tick
// the tick time is set by the carry walking the cell chain, one cell per cycle
// one item at a time; a finished result waits in the output register and a stall holds the input
// rst_n (synchronous, active low) clears the table, entry count and time counter
module preemptive_priority_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_prio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_ran_id,
  output logic [31:0] out_now,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting
);

  ppsch_pkg::state_t state_r, state_nxt;
  ppsch_pkg::cnt_t   count_r, count_nxt;
  ppsch_pkg::idx_t   scan_r, scan_nxt;
  logic [31:0]       clock_r, clock_nxt;
  logic [31:0]       clock_sat;

  logic [2:0]  res_status_r, res_status_nxt;
  logic [15:0] res_id_r, res_id_nxt;
  logic [31:0] res_now_r, res_now_nxt;
  logic [31:0] res_fin_r, res_fin_nxt;
  logic [31:0] res_tat_r, res_tat_nxt;
  logic [31:0] res_wt_r, res_wt_nxt;
  logic [15:0] res_burst_r, res_burst_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  logic [31:0] out_now_r, out_now_nxt;
  logic [31:0] out_fin_r, out_fin_nxt;
  logic [31:0] out_tat_r, out_tat_nxt;
  logic [31:0] out_wt_r, out_wt_nxt;

  logic [ppsch_pkg::PROCS-1:0] wr_en;
  logic [ppsch_pkg::PROCS-1:0] dec_en;
  logic                        restart;

  ppsch_pkg::entry_t ld_data;
  ppsch_pkg::carry_t chain [ppsch_pkg::PROCS+1];
  ppsch_pkg::carry_t best;

  assign ld_data = '{id: in_proc_id, arrival: in_arrival, burst: in_burst, prio: in_prio};
  assign chain[0] = '0;
  assign best     = chain[ppsch_pkg::PROCS];

  for (genvar g = 0; g < ppsch_pkg::PROCS; g++) begin : g_cell
    ppsch_pkg::cell_ctl_t ctl;
    assign ctl = '{wr_en: wr_en[g], dec_en: dec_en[g], restart: restart};
    ppsch_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (ppsch_pkg::idx_t'(g)),
      .ctl       (ctl),
      .ld_data   (ld_data),
      .clock_now (clock_r),
      .cin       (chain[g]),
      .cout      (chain[g+1])
    );
  end

  assign clock_sat = (clock_r == 32'hFFFF_FFFF) ? clock_r : clock_r + 32'd1;
  assign in_ready  = (state_r == ppsch_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppsch_pkg::S_IDLE;
      count_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_now_r    <= res_now_nxt;
    res_fin_r    <= res_fin_nxt;
    res_tat_r    <= res_tat_nxt;
    res_wt_r     <= res_wt_nxt;
    res_burst_r  <= res_burst_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_now_r    <= out_now_nxt;
    out_fin_r    <= out_fin_nxt;
    out_tat_r    <= out_tat_nxt;
    out_wt_r     <= out_wt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    clock_nxt      = clock_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_now_nxt    = res_now_r;
    res_fin_nxt    = res_fin_r;
    res_tat_nxt    = res_tat_r;
    res_wt_nxt     = res_wt_r;
    res_burst_nxt  = res_burst_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_now_nxt    = out_now_r;
    out_fin_nxt    = out_fin_r;
    out_tat_nxt    = out_tat_r;
    out_wt_nxt     = out_wt_r;
    wr_en          = '0;
    dec_en         = '0;
    restart        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ppsch_pkg::S_IDLE: begin
        if (in_valid) begin
          res_fin_nxt = '0;
          res_tat_nxt = '0;
          res_wt_nxt  = '0;
          res_id_nxt  = '0;
          res_now_nxt = clock_r;
          state_nxt   = ppsch_pkg::S_EMIT;
          unique case (in_kind)
            ppsch_pkg::KIND_LOAD: begin
              res_id_nxt = in_proc_id;
              if (in_burst == 16'd0) begin
                res_status_nxt = ppsch_pkg::ST_BADBURST;
              end else if (count_r == ppsch_pkg::cnt_t'(ppsch_pkg::PROCS)) begin
                res_status_nxt = ppsch_pkg::ST_FULL;
              end else begin
                wr_en[count_r[ppsch_pkg::IDX_W-1:0]] = 1'b1;
                count_nxt      = count_r + 1'b1;
                res_status_nxt = ppsch_pkg::ST_LOADED;
              end
            end
            ppsch_pkg::KIND_TICK: begin
              scan_nxt  = '0;
              state_nxt = ppsch_pkg::S_SCAN;
            end
            ppsch_pkg::KIND_RESTART: begin
              restart        = 1'b1;
              clock_nxt      = '0;
              res_now_nxt    = '0;
              res_status_nxt = ppsch_pkg::ST_IDLE;
            end
            default: begin
              res_status_nxt = ppsch_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ppsch_pkg::S_SCAN: begin
        // S_SCAN waits until the carry has passed every cell
        scan_nxt = scan_r + 1'b1;
        if (scan_r == ppsch_pkg::idx_t'(ppsch_pkg::PROCS - 1)) begin
          state_nxt = ppsch_pkg::S_RUN;
        end
      end
      ppsch_pkg::S_RUN: begin
        clock_nxt     = clock_sat;
        res_now_nxt   = clock_sat;
        res_fin_nxt   = '0;
        res_tat_nxt   = '0;
        res_wt_nxt    = '0;
        res_burst_nxt = best.burst;
        state_nxt     = ppsch_pkg::S_EMIT;
        if (!best.found) begin
          res_status_nxt = ppsch_pkg::ST_IDLE;
          res_id_nxt     = '0;
        end else begin
          dec_en[best.idx] = 1'b1;
          res_id_nxt       = best.id;
          if (best.left == 16'd1) begin
            res_status_nxt = ppsch_pkg::ST_DONE;
            res_fin_nxt    = clock_sat;
            res_tat_nxt    = clock_sat - {16'd0, best.arrival};
            state_nxt      = ppsch_pkg::S_CALC;
          end else begin
            res_status_nxt = ppsch_pkg::ST_RAN;
          end
        end
      end
      ppsch_pkg::S_CALC: begin
        // waiting would only go negative once the time counter has saturated; it is clamped to zero
        res_wt_nxt = (res_tat_r >= {16'd0, res_burst_r}) ?
                     res_tat_r - {16'd0, res_burst_r} : 32'd0;
        state_nxt  = ppsch_pkg::S_EMIT;
      end
      ppsch_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_now_nxt    = res_now_r;
          out_fin_nxt    = res_fin_r;
          out_tat_nxt    = res_tat_r;
          out_wt_nxt     = res_wt_r;
          state_nxt      = ppsch_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ppsch_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_ran_id      = out_id_r;
  assign out_now         = out_now_r;
  assign out_finish_time = out_fin_r;
  assign out_turnaround  = out_tat_r;
  assign out_waiting     = out_wt_r;

endmodule

/* sv/ppsch_checker.sv */
`include "preemptive_priority_scheduler_top_macros.svh"

module ppsch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_ran_id,
  input logic [31:0] out_now,
  input logic [31:0] out_finish_time,
  input logic [31:0] out_turnaround,
  input logic [31:0] out_waiting
);

  // only one transaction in flight, so the input closes after each acceptance
  `PPS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // a stalled result transaction holds its status
  `PPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))

  // completion figures are zero unless the process finished
  `PPS_ASSERT_IMP(a_zero_unless_done, clk, rst_n, out_valid && (out_status != ppsch_pkg::ST_DONE), (out_finish_time == 32'd0) && (out_turnaround == 32'd0) && (out_waiting == 32'd0))

  // idle results name no process
  `PPS_ASSERT_IMP(a_idle_no_id, clk, rst_n, out_valid && (out_status == ppsch_pkg::ST_IDLE), out_ran_id == 16'd0)

  // completion times are ordered
  `PPS_ASSERT_IMP(a_done_order, clk, rst_n, out_valid && (out_status == ppsch_pkg::ST_DONE), (out_turnaround <= out_finish_time) && (out_waiting <= out_turnaround) && (out_finish_time == out_now))

endmodule

bind preemptive_priority_scheduler_top ppsch_checker u_ppsch_checker (.*);

/* bench/preemptive_priority_scheduler_top_tb.sv */
`timescale 1ns / 100ps

module preemptive_priority_scheduler_top_tb;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = ppsch_pkg::PROCS + 12;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ran_id;
    logic [31:0] now;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } sched_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [15:0] in_proc_id;
  logic [15:0] in_arrival;
  logic [15:0] in_burst;
  logic [7:0]  in_prio;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [15:0] out_ran_id;
  logic [31:0] out_now;
  logic [31:0] out_finish_time;
  logic [31:0] out_turnaround;
  logic [31:0] out_waiting;

  // scheduler table as the bench sees it
  logic        tbl_valid [ppsch_pkg::PROCS];
  logic [15:0] tbl_id [ppsch_pkg::PROCS];
  logic [15:0] tbl_arrival [ppsch_pkg::PROCS];
  logic [15:0] tbl_burst [ppsch_pkg::PROCS];
  logic [7:0]  tbl_prio [ppsch_pkg::PROCS];
  logic [15:0] tbl_left [ppsch_pkg::PROCS];
  int          tbl_count;
  logic [31:0] sched_clock;

  sched_result_t pending_results[$];
  int mismatch_count;
  int status_count [8];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_left;
  int sent_count;

  preemptive_priority_scheduler_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_proc_id      (in_proc_id),
    .in_arrival      (in_arrival),
    .in_burst        (in_burst),
    .in_prio         (in_prio),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_ran_id      (out_ran_id),
    .out_now         (out_now),
    .out_finish_time (out_finish_time),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic sched_result_t predict_schedule(input logic [1:0] kind,
                                                     input logic [15:0] pid,
                                                     input logic [15:0] arr,
                                                     input logic [15:0] bst,
                                                     input logic [7:0] pri);
    sched_result_t r;
    bit found;
    int sel;
    logic [7:0] best;
    logic [31:0] tat;
    r = '0;
    found = 1'b0;
    sel = 0;
    best = '0;
    case (kind)
      ppsch_pkg::KIND_LOAD: begin
        r.ran_id = pid;
        if (bst == 16'd0) begin
          r.status = ppsch_pkg::ST_BADBURST;
        end else if (tbl_count >= ppsch_pkg::PROCS) begin
          r.status = ppsch_pkg::ST_FULL;
        end else begin
          tbl_valid[tbl_count] = 1'b1;
          tbl_id[tbl_count] = pid;
          tbl_arrival[tbl_count] = arr;
          tbl_burst[tbl_count] = bst;
          tbl_prio[tbl_count] = pri;
          tbl_left[tbl_count] = bst;
          tbl_count++;
          r.status = ppsch_pkg::ST_LOADED;
        end
      end
      ppsch_pkg::KIND_TICK: begin
        for (int i = 0; i < ppsch_pkg::PROCS; i++) begin
          if (tbl_valid[i] && {16'd0, tbl_arrival[i]} <= sched_clock && tbl_left[i] != 0) begin
            // strict compare keeps the earliest-loaded entry on a tie
            if (!found || tbl_prio[i] < best) begin
              found = 1'b1;
              best = tbl_prio[i];
              sel = i;
            end
          end
        end
        if (sched_clock != 32'hFFFF_FFFF) sched_clock++;
        if (!found) begin
          r.status = ppsch_pkg::ST_IDLE;
        end else begin
          tbl_left[sel]--;
          r.ran_id = tbl_id[sel];
          if (tbl_left[sel] != 0) begin
            r.status = ppsch_pkg::ST_RAN;
          end else begin
            r.status = ppsch_pkg::ST_DONE;
            tat = sched_clock - {16'd0, tbl_arrival[sel]};
            r.finish_time = sched_clock;
            r.turnaround = tat;
            // only negative once the clock has saturated
            r.waiting = (tat >= {16'd0, tbl_burst[sel]}) ? tat - {16'd0, tbl_burst[sel]} : '0;
          end
        end
      end
      ppsch_pkg::KIND_RESTART: begin
        for (int i = 0; i < ppsch_pkg::PROCS; i++) begin
          if (tbl_valid[i]) tbl_left[i] = tbl_burst[i];
        end
        sched_clock = '0;
        r.status = ppsch_pkg::ST_IDLE;
      end
      default: begin
        r.status = ppsch_pkg::ST_IDLE;
      end
    endcase
    r.now = sched_clock;
    return r;
  endfunction

  // called at a rising edge, returns at the edge that accepted the transaction
  task automatic send_item(input logic [1:0] kind, input logic [15:0] pid,
                           input logic [15:0] arr, input logic [15:0] bst,
                           input logic [7:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_proc_id <= pid;
    in_arrival <= arr;
    in_burst <= bst;
    in_prio <= pri;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_results.insert(pending_results.size(), predict_schedule(kind, pid, arr, bst, pri));
    sent_count++;
  endtask

  task automatic send_random_item();
    int pick;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0] pri;
    pick = $urandom_range(99);
    arr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(24));
    bst = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    pri = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    if (pick < 10) begin
      send_item(ppsch_pkg::KIND_LOAD, 16'($urandom), arr, bst, pri);
    end else if (pick < 93) begin
      send_item(ppsch_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
    end else if (pick < 96) begin
      send_item(ppsch_pkg::KIND_RESTART, 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
    end else begin
      send_item(KIND_RESERVED, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(ppsch_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0, 8'd0);
    send_item(KIND_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(ppsch_pkg::KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'd0, 8'hFF);
    send_item(ppsch_pkg::KIND_LOAD, 16'hFFFF, 16'd0, 16'd3, 8'hFF);
    // arrives far beyond the run, so its huge burst never starves the others
    send_item(ppsch_pkg::KIND_LOAD, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    send_item(ppsch_pkg::KIND_LOAD, 16'h1234, 16'd2, 16'd1, 8'd0);
    // same priority as the first entry, loses the tie
    send_item(ppsch_pkg::KIND_LOAD, 16'h0005, 16'd0, 16'd2, 8'hFF);
    repeat (7) send_item(ppsch_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom));
    send_item(ppsch_pkg::KIND_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (6) send_item(ppsch_pkg::KIND_TICK, 16'd0, 16'd0, 16'd0, 8'd0);
    wait_for_results();
  endtask

  task automatic test_random_schedule(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random_item();
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering items, filling the block until its input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 200;
    repeat (12) send_random_item();
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // a transaction seen at the falling edge is taken at the next rising edge
  always @(negedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d id %0h",
                 $time, out_status, out_ran_id);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("ran_id", 32'(want.ran_id), 32'(out_ran_id));
        check_field("now", want.now, out_now);
        check_field("finish_time", want.finish_time, out_finish_time);
        check_field("turnaround", want.turnaround, out_turnaround);
        check_field("waiting", want.waiting, out_waiting);
        status_count[out_status]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < ppsch_pkg::PROCS; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    sched_clock = '0;
    mismatch_count = 0;
    sent_count = 0;
    hold_req = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 8; i++) status_count[i] = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= ppsch_pkg::KIND_LOAD;
    in_proc_id <= '0;
    in_arrival <= '0;
    in_burst <= '0;
    in_prio <= '0;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_schedule(170, 0, 0);
    test_output_backpressure();
    test_random_schedule(170, 65, 0);
    test_random_schedule(170, 0, 65);
    test_random_schedule(170, 36, 36);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d transactions over directed, back-pressure and four idling phases",
             sent_count);
    $display("loaded %0d, full %0d, bad burst %0d, idle %0d, ran %0d, completed %0d",
             status_count[ppsch_pkg::ST_LOADED], status_count[ppsch_pkg::ST_FULL],
             status_count[ppsch_pkg::ST_BADBURST], status_count[ppsch_pkg::ST_IDLE],
             status_count[ppsch_pkg::ST_RAN], status_count[ppsch_pkg::ST_DONE]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ppsch_pkg.sv
sv/ppsch_cell.sv
sv/preemptive_priority_scheduler_top.sv
sv/ppsch_checker.sv
bench/preemptive_priority_scheduler_top_tb.sv
